### sv/mlpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlpf_pkg;

  // Fixed field widths of the two channels.
  localparam int VALUE_W = 16;
  localparam int INDEX_W = 8;
  localparam int IDX_W   = 4;

  // Default network shape.
  localparam int DEF_INPUT_COUNT         = 4;
  localparam int DEF_EXTRA_HIDDEN_LAYERS = 1;
  localparam int DEF_HIDDEN_WIDTH        = 8;
  localparam int DEF_OUTPUT_COUNT        = 2;
  localparam int DEF_WEIGHT_DEPTH        = 256;

  // The bias input of every neuron is -1, which is -256 in Q8.8.
  localparam logic signed [VALUE_W-1:0] BIAS_OPERAND = -16'sd256;

  // Command codes of an input beat.
  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Status codes of a result beat.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_COUNT_ERR = 1'b1;

  // One weight term handed from the sequencer to the MAC unit.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             w_zero;
    logic             bank;
    logic [IDX_W-1:0] idx;
  } mac_ctrl_t;

  // A finished neuron value to be written into the activation memory.
  typedef struct packed {
    logic                      valid;
    logic                      bank;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] value;
  } act_wr_t;

endpackage

`default_nettype wire

### sv/mlpf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mlpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/mlpf_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module mlpf_mac #(
  parameter int MAX_TERMS = 9
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mlpf_pkg::mac_ctrl_t                issue,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] w_rdata,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] a_rdata,
  output mlpf_pkg::act_wr_t                       result
);

  import mlpf_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_TERMS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sd32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32'sd32768);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(32'sd128);

  mac_ctrl_t                 ctrl_r;
  mac_ctrl_t                 ctrl_p;
  logic signed [VALUE_W-1:0] op_w;
  logic signed [VALUE_W-1:0] op_a;
  logic signed [PROD_W-1:0]  prod_p;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   fin_sum;
  logic                      fin_valid;
  logic                      fin_bank;
  logic [IDX_W-1:0]          fin_idx;
  logic signed [ACC_W-1:0]   rounded;

  // Stage R: memory data arrives, the product is formed.
  assign op_w = ctrl_r.w_zero ? '0 : w_rdata;
  assign op_a = ctrl_r.last ? BIAS_OPERAND : a_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_r.valid <= 1'b0;
      ctrl_p.valid <= 1'b0;
      fin_valid    <= 1'b0;
    end else begin
      ctrl_r.valid <= issue.valid;
      ctrl_p.valid <= ctrl_r.valid;
      fin_valid    <= ctrl_p.valid && ctrl_p.last;
    end
    ctrl_r.first  <= issue.first;
    ctrl_r.last   <= issue.last;
    ctrl_r.w_zero <= issue.w_zero;
    ctrl_r.bank   <= issue.bank;
    ctrl_r.idx    <= issue.idx;
    ctrl_p.first  <= ctrl_r.first;
    ctrl_p.last   <= ctrl_r.last;
    ctrl_p.w_zero <= ctrl_r.w_zero;
    ctrl_p.bank   <= ctrl_r.bank;
    ctrl_p.idx    <= ctrl_r.idx;
    prod_p        <= op_w * op_a;
  end

  // Stage P: accumulate; the first term of a neuron restarts the sum.
  assign sum = (ctrl_p.first ? '0 : acc) + ACC_W'(prod_p);

  always_ff @(posedge clk) begin
    if (ctrl_p.valid) begin
      acc <= sum;
    end
    fin_sum  <= sum;
    fin_bank <= ctrl_p.bank;
    fin_idx  <= ctrl_p.idx;
  end

  // Stage S: round half up to Q8.8 and saturate to 16 bits.
  assign rounded = (fin_sum + HALF) >>> 8;

  always_comb begin
    result.valid = fin_valid;
    result.bank  = fin_bank;
    result.idx   = fin_idx;
    if (rounded > SAT_HI) begin
      result.value = SAT_HI[VALUE_W-1:0];
    end else if (rounded < SAT_LO) begin
      result.value = SAT_LO[VALUE_W-1:0];
    end else begin
      result.value = rounded[VALUE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/mlpf_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module mlpf_seq #(
  parameter int INPUT_COUNT         = mlpf_pkg::DEF_INPUT_COUNT,
  parameter int EXTRA_HIDDEN_LAYERS = mlpf_pkg::DEF_EXTRA_HIDDEN_LAYERS,
  parameter int HIDDEN_WIDTH        = mlpf_pkg::DEF_HIDDEN_WIDTH,
  parameter int OUTPUT_COUNT        = mlpf_pkg::DEF_OUTPUT_COUNT,
  parameter int WEIGHT_DEPTH        = mlpf_pkg::DEF_WEIGHT_DEPTH,
  parameter int ACT_AW              = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic [mlpf_pkg::INDEX_W-1:0]        weight_index,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] weight_value,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] sample_value,
  input  wire logic                                last_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [mlpf_pkg::VALUE_W-1:0]      output_value,
  output logic [mlpf_pkg::IDX_W-1:0]               output_index,
  output logic                                     last_output,
  output logic                                     status,
  output logic                                     w_we,
  output logic [$clog2(WEIGHT_DEPTH)-1:0]          w_waddr,
  output logic [mlpf_pkg::VALUE_W-1:0]             w_wdata,
  output logic [$clog2(WEIGHT_DEPTH)-1:0]          w_raddr,
  output mlpf_pkg::mac_ctrl_t                      issue,
  input  wire mlpf_pkg::act_wr_t                   mac_wr,
  output logic                                     a_we,
  output logic [ACT_AW:0]                          a_waddr,
  output logic [mlpf_pkg::VALUE_W-1:0]             a_wdata,
  output logic [ACT_AW:0]                          a_raddr,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] a_rdata
);

  import mlpf_pkg::*;

  localparam int AW          = $clog2(WEIGHT_DEPTH);
  localparam int LAYER_COUNT = EXTRA_HIDDEN_LAYERS + 2;
  localparam int LAYER_W     = $clog2(LAYER_COUNT + 1);
  localparam int MAX_NIN     = (INPUT_COUNT > HIDDEN_WIDTH) ? INPUT_COUNT : HIDDEN_WIDTH;
  localparam int K_W         = $clog2(MAX_NIN + 1);
  localparam int CNT_W       = $clog2(INPUT_COUNT + 2);
  localparam int TOTAL_WEIGHTS = HIDDEN_WIDTH * (INPUT_COUNT + 1)
                               + EXTRA_HIDDEN_LAYERS * HIDDEN_WIDTH * (HIDDEN_WIDTH + 1)
                               + OUTPUT_COUNT * (HIDDEN_WIDTH + 1);
  localparam int POS_MAX     = (TOTAL_WEIGHTS > WEIGHT_DEPTH) ? TOTAL_WEIGHTS : WEIGHT_DEPTH;
  localparam int POS_W       = $clog2(POS_MAX + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ERR   = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] count_inc;
  logic [LAYER_W-1:0] layer;
  logic [IDX_W-1:0] n;
  logic [K_W-1:0]   k;
  logic [POS_W-1:0] pos;
  logic [1:0]       drain_cnt;
  logic             primed;

  logic             accept;
  logic             take_sample;
  logic             layer_last;
  logic [K_W-1:0]   nin;
  logic [IDX_W-1:0] nout_m1;
  logic             term_last;
  logic             neuron_last;
  logic             out_free;
  logic             load_err;
  logic             load_res;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign take_sample = accept && (command == CMD_SAMPLE);
  assign count_inc   = (sample_count <= CNT_W'(INPUT_COUNT)) ? sample_count + 1'b1
                                                              : sample_count;

  assign layer_last  = (layer == LAYER_W'(LAYER_COUNT - 1));
  assign nin         = (layer == '0) ? K_W'(INPUT_COUNT) : K_W'(HIDDEN_WIDTH);
  assign nout_m1     = layer_last ? IDX_W'(OUTPUT_COUNT - 1) : IDX_W'(HIDDEN_WIDTH - 1);
  assign term_last   = (k == nin);
  assign neuron_last = (n == nout_m1);

  assign out_free = !out_valid || !out_stall;
  assign load_err = (state == ST_ERR) && out_free;
  assign load_res = (state == ST_EMIT) && primed && out_free;

  // Weight loads go straight into the weight memory.
  assign w_we    = accept && (command == CMD_WEIGHT)
                   && (32'(weight_index) < 32'(WEIGHT_DEPTH));
  assign w_waddr = AW'(weight_index);
  assign w_wdata = weight_value;
  assign w_raddr = pos[AW-1:0];

  // One weight term per cycle while a layer streams through the MAC unit.
  always_comb begin
    issue.valid  = (state == ST_RUN);
    issue.first  = (k == '0);
    issue.last   = term_last;
    issue.w_zero = (pos >= POS_W'(WEIGHT_DEPTH));
    issue.bank   = ~layer[0];
    issue.idx    = n;
  end

  // Samples and neuron results never coincide: samples come only while idle.
  always_comb begin
    if (mac_wr.valid) begin
      a_we    = 1'b1;
      a_waddr = {mac_wr.bank, ACT_AW'(mac_wr.idx)};
      a_wdata = mac_wr.value;
    end else begin
      a_we    = take_sample && (sample_count < CNT_W'(INPUT_COUNT));
      a_waddr = {1'b0, ACT_AW'(sample_count)};
      a_wdata = sample_value;
    end
  end

  assign a_raddr = (state == ST_EMIT) ? {layer[0], ACT_AW'(n)} : {layer[0], ACT_AW'(k)};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_sample && last_sample) begin
          state_next = (count_inc == CNT_W'(INPUT_COUNT)) ? ST_RUN : ST_ERR;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (term_last && neuron_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'd2) begin
          state_next = (layer == LAYER_W'(LAYER_COUNT)) ? ST_EMIT : ST_RUN;
        end
      end
      ST_EMIT: begin
        if (load_res && (n == IDX_W'(OUTPUT_COUNT - 1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= '0;
      layer        <= '0;
      n            <= '0;
      k            <= '0;
      pos          <= '0;
      drain_cnt    <= '0;
      primed       <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (take_sample) begin
            sample_count <= last_sample ? '0 : count_inc;
          end
          layer     <= '0;
          n         <= '0;
          k         <= '0;
          pos       <= '0;
          drain_cnt <= '0;
        end
        ST_ERR: begin
        end
        ST_RUN: begin
          pos <= pos + 1'b1;
          if (term_last) begin
            k <= '0;
            if (neuron_last) begin
              n     <= '0;
              layer <= layer + 1'b1;
            end else begin
              n <= n + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt == 2'd2) begin
            drain_cnt <= '0;
            primed    <= 1'b0;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!primed) begin
            primed <= 1'b1;
          end else if (out_free) begin
            n      <= n + 1'b1;
            primed <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_err || load_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      output_value <= '0;
      output_index <= '0;
      last_output  <= 1'b1;
      status       <= STATUS_COUNT_ERR;
    end else if (load_res) begin
      output_value <= a_rdata;
      output_index <= n;
      last_output  <= (n == IDX_W'(OUTPUT_COUNT - 1));
      status       <= STATUS_OK;
    end
  end

endmodule

`default_nettype wire

### sv/mlp_feedforward_inference_unit.sv
// Feedforward perceptron inference engine, signed Q8.8, linear neurons.
// Input channel (in_valid / in_stall): each beat either loads one weight
// (command 0, weight_index and weight_value) or presents one network input
// (command 1, sample_value, last_sample on the final element). Weight and
// ordinary sample beats are taken back to back. The beat that carries
// last_sample starts a run and the input channel stalls until the run is
// finished. A run walks every weight once through a single
// multiply-accumulate unit fed by the weight memory's read port, one weight
// per cycle, with a drain state after each layer so the next layer sees the
// finished activations. It then reads out the output layer one result at a
// time, priming the activation read before it loads each result.
// TOTAL_WEIGHTS is 130 with the default shape. A vector of the wrong length
// gives a single error result instead.
// Output channel (out_valid / out_stall): one beat per output neuron, the
// last one flagged by last_output; a stalled result holds in the output
// register and the run pauses at that point.
// Reset clears the sample count and control state; the weight memory keeps
// whatever it held and must be loaded before the first run.
`timescale 1ns / 1ps
`default_nettype none

module mlp_feedforward_inference_unit #(
  parameter int INPUT_COUNT         = mlpf_pkg::DEF_INPUT_COUNT,
  parameter int EXTRA_HIDDEN_LAYERS = mlpf_pkg::DEF_EXTRA_HIDDEN_LAYERS,
  parameter int HIDDEN_WIDTH        = mlpf_pkg::DEF_HIDDEN_WIDTH,
  parameter int OUTPUT_COUNT        = mlpf_pkg::DEF_OUTPUT_COUNT,
  parameter int WEIGHT_DEPTH        = mlpf_pkg::DEF_WEIGHT_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic [mlpf_pkg::INDEX_W-1:0]        weight_index,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] weight_value,
  input  wire logic signed [mlpf_pkg::VALUE_W-1:0] sample_value,
  input  wire logic                                last_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [mlpf_pkg::VALUE_W-1:0]      output_value,
  output logic [mlpf_pkg::IDX_W-1:0]               output_index,
  output logic                                     last_output,
  output logic                                     status
);

  import mlpf_pkg::*;

  localparam int AW        = $clog2(WEIGHT_DEPTH);
  localparam int ACT_DEPTH = (INPUT_COUNT > HIDDEN_WIDTH)
                           ? ((INPUT_COUNT > OUTPUT_COUNT) ? INPUT_COUNT : OUTPUT_COUNT)
                           : ((HIDDEN_WIDTH > OUTPUT_COUNT) ? HIDDEN_WIDTH : OUTPUT_COUNT);
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int MAX_TERMS = ((INPUT_COUNT > HIDDEN_WIDTH) ? INPUT_COUNT : HIDDEN_WIDTH) + 1;

  // Weight memory port signals.
  logic               w_we;
  logic [AW-1:0]      w_waddr;
  logic [VALUE_W-1:0] w_wdata;
  logic [AW-1:0]      w_raddr;
  logic [VALUE_W-1:0] w_rdata;

  // Activation memory: two banks of 2**ACT_AW (at least ACT_DEPTH) entries, ping-ponged by layer.
  logic               a_we;
  logic [ACT_AW:0]    a_waddr;
  logic [VALUE_W-1:0] a_wdata;
  logic [ACT_AW:0]    a_raddr;
  logic [VALUE_W-1:0] a_rdata;

  mac_ctrl_t issue;
  act_wr_t   mac_wr;

  mlpf_seq #(
    .INPUT_COUNT        (INPUT_COUNT),
    .EXTRA_HIDDEN_LAYERS(EXTRA_HIDDEN_LAYERS),
    .HIDDEN_WIDTH       (HIDDEN_WIDTH),
    .OUTPUT_COUNT       (OUTPUT_COUNT),
    .WEIGHT_DEPTH       (WEIGHT_DEPTH),
    .ACT_AW             (ACT_AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .weight_index(weight_index),
    .weight_value(weight_value),
    .sample_value(sample_value),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .output_value(output_value),
    .output_index(output_index),
    .last_output (last_output),
    .status      (status),
    .w_we        (w_we),
    .w_waddr     (w_waddr),
    .w_wdata     (w_wdata),
    .w_raddr     (w_raddr),
    .issue       (issue),
    .mac_wr      (mac_wr),
    .a_we        (a_we),
    .a_waddr     (a_waddr),
    .a_wdata     (a_wdata),
    .a_raddr     (a_raddr),
    .a_rdata     ($signed(a_rdata))
  );

  mlpf_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(WEIGHT_DEPTH)
  ) u_weight_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(w_wdata),
    .raddr(w_raddr),
    .rdata(w_rdata)
  );

  mlpf_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(2 ** (ACT_AW + 1))
  ) u_act_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  mlpf_mac #(
    .MAX_TERMS(MAX_TERMS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .w_rdata($signed(w_rdata)),
    .a_rdata($signed(a_rdata)),
    .result (mac_wr)
  );

endmodule

`default_nettype wire

### sv/mlpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mlpf_checker #(
  parameter int OUTPUT_COUNT = mlpf_pkg::DEF_OUTPUT_COUNT
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         command,
  input wire logic [mlpf_pkg::INDEX_W-1:0] weight_index,
  input wire logic [mlpf_pkg::VALUE_W-1:0] weight_value,
  input wire logic [mlpf_pkg::VALUE_W-1:0] sample_value,
  input wire logic                         last_sample,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [mlpf_pkg::VALUE_W-1:0] output_value,
  input wire logic [mlpf_pkg::IDX_W-1:0]   output_index,
  input wire logic                         last_output,
  input wire logic                         status
);

  import mlpf_pkg::*;

  logic in_take;
  assign in_take = in_valid && !in_stall;

  // The end of a vector always starts a run or an error report.
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    in_take && (command == CMD_SAMPLE) && last_sample |=> in_stall)
    else $error("input not held off after the final sample");

  // Weight loads and ordinary samples leave the block ready for more.
  a_stays_open: assert property (@(posedge clk) disable iff (rst)
    in_take && !((command == CMD_SAMPLE) && last_sample) |=> !in_stall)
    else $error("input held off after a load or ordinary sample");

  // An error report is a lone, final result for index zero.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_COUNT_ERR) |-> (output_index == '0) && last_output)
    else $error("malformed count error result");

  // A good run closes on the last output neuron.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_OK) && last_output
      |-> (output_index == IDX_W'(OUTPUT_COUNT - 1)))
    else $error("final result carries the wrong neuron index");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(output_value) && $stable(output_index))
    else $error("stalled result changed");

endmodule

bind mlp_feedforward_inference_unit mlpf_checker #(
  .OUTPUT_COUNT(OUTPUT_COUNT)
) u_mlpf_checker (.*);

`default_nettype wire

### dv/mlp_feedforward_inference_unit_tb.sv
`timescale 1ns / 1ps

module mlp_feedforward_inference_unit_tb;

  import mlpf_pkg::*;

  // Number of weights that one pass through the default network reads.
  localparam int TOTAL_W = (DEF_INPUT_COUNT + 1) * DEF_HIDDEN_WIDTH
                         + DEF_EXTRA_HIDDEN_LAYERS * (DEF_HIDDEN_WIDTH + 1) * DEF_HIDDEN_WIDTH
                         + DEF_OUTPUT_COUNT * (DEF_HIDDEN_WIDTH + 1);
  // Cycles without any accepted beat on either channel before the run is abandoned.
  // The longest quiet stretch is the long result hold-off plus one full inference.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          index;
    logic                      last;
    logic                      status;
  } neuron_result_t;

  // Shadow of the network: it mirrors every accepted input beat and keeps the
  // queue of output neuron values that the block still owes us.
  class inference_scoreboard;
    logic signed [VALUE_W-1:0] weights [DEF_WEIGHT_DEPTH];
    logic signed [VALUE_W-1:0] vector [DEF_INPUT_COUNT];
    int unsigned               taken;
    neuron_result_t            pending_outputs [$];
    int                        results_due;
    int                        checked;
    int                        mismatches;

    function new();
      taken       = 0;
      results_due = 0;
      checked     = 0;
      mismatches  = 0;
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Evaluates every layer in Q8.8 with an exact wide sum per neuron, then
    // queues one result per output neuron.
    function void forward_pass();
      logic signed [VALUE_W-1:0] src [16];
      logic signed [VALUE_W-1:0] dst [16];
      neuron_result_t            res;
      longint                    acc;
      int                        pos;
      int                        fan_in;
      int                        width;
      pos = 0;
      src = '{default: '0};
      dst = '{default: '0};
      foreach (vector[k]) src[k] = vector[k];
      for (int layer = 0; layer < DEF_EXTRA_HIDDEN_LAYERS + 2; layer++) begin
        fan_in = (layer == 0) ? DEF_INPUT_COUNT : DEF_HIDDEN_WIDTH;
        width  = (layer == DEF_EXTRA_HIDDEN_LAYERS + 1) ? DEF_OUTPUT_COUNT : DEF_HIDDEN_WIDTH;
        for (int n = 0; n < width; n++) begin
          acc = 0;
          for (int k = 0; k < fan_in; k++) begin
            acc += longint'(weights[pos]) * longint'(src[k]);
            pos++;
          end
          // The last weight of each neuron multiplies the constant bias input.
          acc += longint'(weights[pos]) * longint'(BIAS_OPERAND);
          pos++;
          // Round half up to Q8.8, then clamp to the 16-bit range.
          acc = (acc + 128) >>> 8;
          if (acc > 32767) dst[n] = 16'sh7fff;
          else if (acc < -32768) dst[n] = 16'sh8000;
          else dst[n] = acc[VALUE_W-1:0];
        end
        src = dst;
      end
      for (int n = 0; n < DEF_OUTPUT_COUNT; n++) begin
        res.value  = src[n];
        res.index  = IDX_W'(n);
        res.last   = (n == DEF_OUTPUT_COUNT - 1);
        res.status = STATUS_OK;
        pending_outputs.insert(pending_outputs.size(), res);
        results_due++;
      end
    endfunction

    function void note_beat(logic cmd, logic [INDEX_W-1:0] idx,
                            logic signed [VALUE_W-1:0] wval, logic signed [VALUE_W-1:0] sval,
                            logic last);
      neuron_result_t err;
      if (cmd == CMD_WEIGHT) begin
        if (idx < DEF_WEIGHT_DEPTH) weights[idx] = wval;
      end else begin
        // Samples past the vector length are dropped; the count stops one above it.
        if (taken < DEF_INPUT_COUNT) vector[taken] = sval;
        if (taken <= DEF_INPUT_COUNT) taken++;
        if (last) begin
          if (taken != DEF_INPUT_COUNT) begin
            err.value  = '0;
            err.index  = '0;
            err.last   = 1'b1;
            err.status = STATUS_COUNT_ERR;
            pending_outputs.insert(pending_outputs.size(), err);
            results_due++;
          end else begin
            forward_pass();
          end
          taken = 0;
        end
      end
    endfunction

    task check_result(logic signed [VALUE_W-1:0] value, logic [IDX_W-1:0] index,
                      logic last, logic stat);
      neuron_result_t want;
      checked++;
      if (pending_outputs.size() == 0) begin
        report($sformatf("result value %0d index %0d with nothing outstanding", value, index));
        return;
      end
      want = pending_outputs.pop_front();
      if (value !== want.value || index !== want.index || last !== want.last ||
          stat !== want.status)
        report($sformatf("got value %0d index %0d last %0b status %0b, want %0d %0d %0b %0b",
                         value, index, last, stat,
                         want.value, want.index, want.last, want.status));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      command;
  logic [INDEX_W-1:0]        weight_index;
  logic signed [VALUE_W-1:0] weight_value;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      last_sample;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] output_value;
  logic [IDX_W-1:0]          output_index;
  logic                      last_output;
  logic                      status;

  inference_scoreboard sb;
  int                  in_idle_pct;
  int                  out_idle_pct;
  int                  beats_sent;
  int                  quiet_cycles;

  always #1 clk = ~clk;

  mlp_feedforward_inference_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .weight_index (weight_index),
    .weight_value (weight_value),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .output_value (output_value),
    .output_index (output_index),
    .last_output  (last_output),
    .status       (status)
  );

  // Both channels are observed at the rising edge. An accepted input beat
  // updates the shadow network; an accepted result is checked against the
  // oldest outstanding one. The watchdog counts cycles in which neither
  // channel moves a beat.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall)
        sb.note_beat(command, weight_index, weight_value, sample_value, last_sample);
      if (out_valid && !out_stall)
        sb.check_result(output_value, output_index, last_output, status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side. It stalls at random according to the current idling rate,
  // and once, after fourteen results have been checked, holds off for a long stretch
  // so that a finished run backs up and the input channel stalls behind it.
  initial begin : result_sink
    int hold;
    bit held;
    hold      = 0;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= 14) begin
        hold = HOLDOFF_CYCLES;
        held = 1;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Weights are mostly small, so that the network does not simply saturate,
  // with a share of full-range values and extremes.
  function automatic logic signed [VALUE_W-1:0] pick_weight();
    int                        r;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(99);
    if (r < 70) v = VALUE_W'($urandom_range(256) - 128);
    else if (r < 90) v = VALUE_W'($urandom);
    else v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    return v;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_sample();
    int                        r;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(99);
    if (r < 60) v = VALUE_W'($urandom_range(2048) - 1024);
    else if (r < 90) v = VALUE_W'($urandom);
    else v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    return v;
  endfunction

  // Drives one input beat. It is entered just after a falling edge, may idle
  // first, then holds the beat steady until it is accepted, and returns just
  // after the following falling edge.
  task automatic send_beat(input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] wval,
                           input logic signed [VALUE_W-1:0] sval, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    weight_index <= idx;
    weight_value <= wval;
    sample_value <= sval;
    last_sample  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // The fields that a beat does not use carry random values.
  task automatic send_weight(input int idx, input logic signed [VALUE_W-1:0] v);
    send_beat(CMD_WEIGHT, INDEX_W'(idx), v, VALUE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_sample(input logic signed [VALUE_W-1:0] v, input logic last);
    send_beat(CMD_SAMPLE, INDEX_W'($urandom), VALUE_W'($urandom), v, last);
  endtask

  // A vector of len samples, last_sample on the final one, with weight writes
  // slipped in between samples at the given rate.
  task automatic send_vector(input int len, input bit fixed,
                             input logic signed [VALUE_W-1:0] val, input int mix_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < mix_pct) send_weight($urandom_range(255), pick_weight());
      send_sample(fixed ? val : pick_sample(), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int due_before;
    int first_beat;
    int pick;
    int len;
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_WEIGHT;
    weight_index = '0;
    weight_value = '0;
    sample_value = '0;
    last_sample  = 1'b0;
    beats_sent   = 0;
    in_idle_pct  = 14;
    out_idle_pct = 65;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Count errors first: these never read the weight store, which is still
    // unwritten. A lone last sample is too short; the second vector has six
    // samples, so the count saturates, and a weight beat carrying last_sample
    // in the middle must not end it.
    send_sample(16'sh7fff, 1'b1);
    repeat (3) send_sample(pick_sample(), 1'b0);
    send_beat(CMD_WEIGHT, 8'hff, 16'sh8000, 16'sh7fff, 1'b1);
    repeat (2) send_sample(pick_sample(), 1'b0);
    send_sample(16'sh8000, 1'b1);

    // Load every weight of the network. Full-scale inputs of both signs then
    // push the layers into saturation, and a zero vector leaves only the bias
    // terms. One more vector has weight writes mixed in.
    for (int i = 0; i < TOTAL_W; i++) send_weight(i, pick_weight());
    send_weight(TOTAL_W - 1, 16'sh8000);
    send_vector(DEF_INPUT_COUNT, 1, 16'sh7fff, 0);
    send_vector(DEF_INPUT_COUNT, 1, 16'sh8000, 0);
    send_vector(DEF_INPUT_COUNT, 1, 16'sh0000, 0);
    send_vector(DEF_INPUT_COUNT, 0, '0, 50);

    // Random part: mostly well-formed vectors, with weight bursts, vectors of
    // the wrong length and stray beats of any kind. The idling rates change
    // by thirds.
    due_before = sb.results_due;
    first_beat = beats_sent;
    while (beats_sent - first_beat < 40 || sb.results_due - due_before < 12) begin
      if (beats_sent - first_beat < 14) begin
        in_idle_pct  = 14;
        out_idle_pct = 65;
      end else if (beats_sent - first_beat < 27) begin
        in_idle_pct  = 65;
        out_idle_pct = 14;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_vector(DEF_INPUT_COUNT, 0, '0, 20);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) send_weight($urandom_range(255), pick_weight());
      end else if (pick < 90) begin
        len = $urandom_range(1, 6);
        if (len >= DEF_INPUT_COUNT) len++;
        send_vector(len, 0, '0, 10);
      end else begin
        send_beat(1'($urandom), INDEX_W'($urandom), VALUE_W'($urandom),
                  VALUE_W'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then give the block at least the length of
    // one inference to show any stray beat.
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/mlpf_pkg.sv
sv/mlpf_ram.sv
sv/mlpf_mac.sv
sv/mlpf_seq.sv
sv/mlp_feedforward_inference_unit.sv
sv/mlpf_checker.sv
dv/mlp_feedforward_inference_unit_tb.sv
